### design/hann_windowed_stft_unit_assert.svh
// Assertion macros shared by the checker
`ifndef HANN_WINDOWED_STFT_UNIT_ASSERT_SVH
`define HANN_WINDOWED_STFT_UNIT_ASSERT_SVH

// Consequent must hold whenever the antecedent holds, outside reset
`define HWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold on the cycle after the antecedent, also across reset
`define HWS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/hws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hws_pkg;

    localparam int WinSize   = 64;
    localparam int HalfWin   = WinSize / 2;
    localparam int IdxW      = 6;
    localparam int HopW      = 11;
    localparam int CntW      = 10;
    localparam int SampW     = 16;
    localparam int CoefW     = 17;
    localparam int ProdW     = SampW + CoefW;
    localparam int AccW      = 38;
    localparam int BinW      = 23;
    localparam logic [HopW-1:0] HopReset = 11'd16;
    localparam logic [HopW-1:0] HopMax   = 11'd1024;

    // Angle steps for the window and twiddle tables
    localparam real Pi       = 3.14159265358979323846;
    localparam real HannStep = 2.0 * Pi / (WinSize - 1);
    localparam real TwidStep = 2.0 * Pi / WinSize;

    typedef logic signed [CoefW-1:0] t_coef;
    typedef t_coef t_coef_tab [0:WinSize-1];

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COPY,
        BK_CDRAIN,
        BK_BIN,
        BK_BDRAIN,
        BK_EMIT
    } t_back_state;

    // Status and ring read request from the back end to the front end
    typedef struct packed {
        logic            copy_busy;
        logic [IdxW-1:0] ring_addr;
    } t_back_status;

    function automatic t_coef f_round(input real v);
        if (v >= 0.0) begin
            return t_coef'($rtoi(v + 0.5));
        end
        return t_coef'(-$rtoi(0.5 - v));
    endfunction

    function automatic t_coef_tab f_hann_tab();
        t_coef_tab t;
        for (int n = 0; n < WinSize; n++) begin
            t[n] = f_round(16384.0 * (1.0 - $cos(HannStep * n)));
        end
        return t;
    endfunction

    function automatic t_coef_tab f_cos_tab();
        t_coef_tab t;
        for (int n = 0; n < WinSize; n++) begin
            t[n] = f_round(32768.0 * $cos(TwidStep * n));
        end
        return t;
    endfunction

    function automatic t_coef_tab f_sin_tab();
        t_coef_tab t;
        for (int n = 0; n < WinSize; n++) begin
            t[n] = f_round(32768.0 * $sin(TwidStep * n));
        end
        return t;
    endfunction

    localparam t_coef_tab HannTab = f_hann_tab();
    localparam t_coef_tab CosTab  = f_cos_tab();
    localparam t_coef_tab SinTab  = f_sin_tab();

endpackage
`default_nettype wire

### design/hann_windowed_stft_unit.sv
// Order: after a window's last sample is taken, the window is copied out of the
// sample ring, then its bins follow one by one (64 products plus pipeline drain each).
// Throughput: the bin engine does one complex multiply per cycle and takes the next
// window only after the last bin is queued; samples are taken one per cycle except
// while a window is being copied out of the sample ring or one is waiting to be copied.
// Reset: synchronous, active low; clears counters, queues and sets the hop to 16.
`timescale 1ns / 1ps
`default_nettype none
module hann_windowed_stft_unit
    import hws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [SampW-1:0] i_sample,
    input  wire logic                    i_first,
    output logic                         empty,
    input  wire logic                    pop,
    output logic [IdxW-1:0]              o_bin_index,
    output logic signed [BinW-1:0]       o_bin_real,
    output logic signed [BinW-1:0]       o_bin_imag,
    output logic                         o_last_bin,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [HopW-1:0]         i_cfg_data
);
    t_back_status            status;
    logic                    job_push;
    logic [IdxW-1:0]         job_start_in;
    logic                    job_pop;
    logic                    job_valid;
    logic [IdxW-1:0]         job_start;
    logic signed [SampW-1:0] ring_data;

    assign o_cfg_ready = 1'b1;

    hws_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_sample      (i_sample),
        .i_first       (i_first),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_job_pending (job_valid),
        .i_status      (status),
        .o_job_push    (job_push),
        .o_job_start   (job_start_in),
        .o_ring_data   (ring_data)
    );

    hws_job_queue u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_start (job_start_in),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_start (job_start)
    );

    hws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job_start (job_start),
        .o_job_pop   (job_pop),
        .o_status    (status),
        .i_ring_data (ring_data),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_bin_index (o_bin_index),
        .o_bin_real  (o_bin_real),
        .o_bin_imag  (o_bin_imag),
        .o_last_bin  (o_last_bin)
    );
endmodule
`default_nettype wire

### design/hws_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module hws_job_queue
    import hws_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [IdxW-1:0] i_start,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic [IdxW-1:0]      o_start
);
    logic [IdxW-1:0] r_slot [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    // Store window start positions in arrival order
    always_ff @(posedge i_clk) begin
        if (i_push && r_cnt != 2'd2) begin
            r_slot[r_wr] <= i_start;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && r_cnt != 2'd2 && !(i_pop && r_cnt != 2'd0)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!(i_push && r_cnt != 2'd2) && i_pop && r_cnt != 2'd0) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && r_cnt != 2'd2) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && r_cnt != 2'd0) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_start = r_slot[r_rd];
endmodule
`default_nettype wire

### design/hws_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hws_front
    import hws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic signed [SampW-1:0] i_sample,
    input  wire logic                    i_first,
    input  wire logic                    i_cfg_valid,
    input  wire logic [HopW-1:0]         i_cfg_data,
    input  wire logic                    i_job_pending,
    input  wire t_back_status            i_status,
    output logic                         o_job_push,
    output logic [IdxW-1:0]              o_job_start,
    output logic signed [SampW-1:0]      o_ring_data
);
    logic signed [SampW-1:0] r_ring [WinSize];
    logic [IdxW:0]           r_seen;
    logic [CntW-1:0]         r_hop_cnt;
    logic [IdxW-1:0]         r_wptr;
    logic [HopW-1:0]         r_hop;
    logic [IdxW:0]           n_seen;
    logic [CntW-1:0]         n_hop_cnt;
    logic [IdxW:0]           seen_base;
    logic [CntW-1:0]         cnt_base;
    logic [HopW-1:0]         hop_eff;
    logic                    accept;
    logic                    emit;

    assign o_full = i_job_pending || i_status.copy_busy;
    assign accept = i_push && !o_full;

    // Clamp the hop into its legal range
    always_comb begin
        hop_eff = r_hop;
        if (r_hop == '0) begin
            hop_eff = HopW'(1);
        end else if (r_hop > HopMax) begin
            hop_eff = HopMax;
        end
    end

    // Classify each sample: count toward a full window, then count down the hop
    always_comb begin
        seen_base = i_first ? '0 : r_seen;
        cnt_base  = i_first ? '0 : r_hop_cnt;
        n_seen    = (seen_base < (IdxW+1)'(WinSize)) ? seen_base + 1'b1 : seen_base;
        n_hop_cnt = cnt_base;
        emit      = 1'b0;
        if (n_seen == (IdxW+1)'(WinSize)) begin
            if (cnt_base != '0) begin
                n_hop_cnt = cnt_base - 1'b1;
            end else begin
                n_hop_cnt = CntW'(hop_eff - 1'b1);
                emit      = 1'b1;
            end
        end
    end

    assign o_job_push  = accept && emit;
    assign o_job_start = r_wptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_hop_cnt <= '0;
            r_wptr    <= '0;
            r_hop     <= HopReset;
        end else begin
            if (i_cfg_valid) begin
                r_hop <= i_cfg_data;
            end
            if (accept) begin
                r_seen    <= n_seen;
                r_hop_cnt <= n_hop_cnt;
                r_wptr    <= r_wptr + 1'b1;
            end
        end
    end

    // Write the sample ring, read it for the back end
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wptr] <= i_sample;
        end
        o_ring_data <= r_ring[i_status.ring_addr];
    end
endmodule
`default_nettype wire

### design/hws_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hws_back
    import hws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_job_valid,
    input  wire logic [IdxW-1:0]         i_job_start,
    output logic                         o_job_pop,
    output t_back_status                 o_status,
    input  wire logic signed [SampW-1:0] i_ring_data,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic [IdxW-1:0]              o_bin_index,
    output logic signed [BinW-1:0]       o_bin_real,
    output logic signed [BinW-1:0]       o_bin_imag,
    output logic                         o_last_bin
);
    t_back_state             r_state;
    t_back_state             n_state;
    logic [IdxW-1:0]         r_n;
    logic [IdxW-1:0]         r_k;
    logic [IdxW-1:0]         r_m;
    logic [IdxW-1:0]         r_start;
    logic [1:0]              r_cv;
    logic [IdxW-1:0]         r_cn1;
    logic [IdxW-1:0]         r_cn2;
    logic signed [ProdW-1:0] r_wprod;
    logic signed [ProdW-1:0] wsum;
    logic signed [SampW-1:0] r_win [WinSize];
    logic signed [SampW-1:0] r_win_q;
    logic [1:0]              r_bv;
    logic [IdxW-1:0]         r_m1;
    logic signed [ProdW-1:0] r_pre_re;
    logic signed [ProdW-1:0] r_pre_im;
    logic signed [AccW-1:0]  r_acc_re;
    logic signed [AccW-1:0]  r_acc_im;
    logic signed [AccW-1:0]  rnd_re;
    logic signed [AccW-1:0]  rnd_im;
    logic [IdxW-1:0]         r_q_idx  [2];
    logic [BinW-1:0]         r_q_re   [2];
    logic [BinW-1:0]         r_q_im   [2];
    logic                    r_q_last [2];
    logic                    r_q_wr;
    logic                    r_q_rd;
    logic [1:0]              r_q_cnt;
    logic                    issue_copy;
    logic                    issue_bin;
    logic                    emit;
    logic                    acc_clr;
    logic                    last_k;
    logic                    pop_ok;

    assign last_k = (r_k == IdxW'(HalfWin));
    assign pop_ok = i_pop && (r_q_cnt != 2'd0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (i_job_valid) n_state = BK_COPY;
            BK_COPY:   if (r_n == IdxW'(WinSize - 1)) n_state = BK_CDRAIN;
            BK_CDRAIN: if (r_cv == 2'b00) n_state = BK_BIN;
            BK_BIN:    if (r_n == IdxW'(WinSize - 1)) n_state = BK_BDRAIN;
            BK_BDRAIN: if (r_bv == 2'b00) n_state = BK_EMIT;
            BK_EMIT:   if (r_q_cnt != 2'd2) n_state = last_k ? BK_IDLE : BK_BIN;
            default:   n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_job_pop  = 1'b0;
        issue_copy = 1'b0;
        issue_bin  = 1'b0;
        emit       = 1'b0;
        acc_clr    = 1'b0;
        case (r_state)
            BK_IDLE:   o_job_pop  = i_job_valid;
            BK_COPY:   issue_copy = 1'b1;
            BK_CDRAIN: acc_clr    = (r_cv == 2'b00);
            BK_BIN:    issue_bin  = 1'b1;
            BK_BDRAIN: ;
            BK_EMIT: begin
                emit    = (r_q_cnt != 2'd2);
                acc_clr = emit;
            end
            default: ;
        endcase
    end

    assign o_status.copy_busy = (r_state == BK_COPY) || (r_state == BK_CDRAIN);
    assign o_status.ring_addr = r_start + r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_n     <= '0;
            r_k     <= '0;
            r_m     <= '0;
            r_cv    <= 2'b00;
            r_bv    <= 2'b00;
        end else begin
            r_state <= n_state;
            r_cv    <= {r_cv[0], issue_copy};
            r_bv    <= {r_bv[0], issue_bin};
            if (o_job_pop) begin
                r_n <= '0;
            end else if (issue_copy || issue_bin) begin
                r_n <= r_n + 1'b1;
            end
            if (issue_bin) begin
                r_m <= r_m + r_k;
            end else if (acc_clr) begin
                r_m <= '0;
            end
            if (r_state == BK_CDRAIN) begin
                r_k <= '0;
            end else if (emit) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Window the samples: ring read, multiply by Hann, round into the window store
    assign wsum = r_wprod + ProdW'(16384);
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_start <= i_job_start;
        end
        r_cn1   <= r_n;
        r_cn2   <= r_cn1;
        r_wprod <= ProdW'(i_ring_data) * ProdW'(HannTab[r_cn1]);
        if (r_cv[1]) begin
            r_win[r_cn2] <= wsum[SampW+14:15];
        end
    end

    // Bin sums: read window, multiply by twiddles, accumulate
    always_ff @(posedge i_clk) begin
        r_win_q  <= r_win[r_n];
        r_m1     <= r_m;
        r_pre_re <= ProdW'(r_win_q) * ProdW'(CosTab[r_m1]);
        r_pre_im <= ProdW'(r_win_q) * ProdW'(SinTab[r_m1]);
        if (acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_bv[1]) begin
            r_acc_re <= r_acc_re + AccW'(r_pre_re);
            r_acc_im <= r_acc_im - AccW'(r_pre_im);
        end
    end

    assign rnd_re = r_acc_re + AccW'(16384);
    assign rnd_im = r_acc_im + AccW'(16384);

    // Result queue between the bin engine and the output ports
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q_idx[r_q_wr]  <= r_k;
            r_q_re[r_q_wr]   <= rnd_re[BinW+14:15];
            r_q_im[r_q_wr]   <= rnd_im[BinW+14:15];
            r_q_last[r_q_wr] <= last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= 1'b0;
            r_q_rd  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (emit) begin
                r_q_wr <= ~r_q_wr;
            end
            if (pop_ok) begin
                r_q_rd <= ~r_q_rd;
            end
            if (emit && !pop_ok) begin
                r_q_cnt <= r_q_cnt + 2'd1;
            end else if (!emit && pop_ok) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    assign o_empty     = (r_q_cnt == 2'd0);
    assign o_bin_index = r_q_idx[r_q_rd];
    assign o_bin_real  = r_q_re[r_q_rd];
    assign o_bin_imag  = r_q_im[r_q_rd];
    assign o_last_bin  = r_q_last[r_q_rd];
endmodule
`default_nettype wire

### design/hws_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hann_windowed_stft_unit_assert.svh"
module hws_checker
    import hws_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    push,
    input wire logic                    full,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire logic [IdxW-1:0]         o_bin_index,
    input wire logic                    o_last_bin,
    input wire logic                    o_cfg_ready
);
    // Queues come out of reset drained
    `HWS_ASSERT_NEXT(a_empty_after_reset, i_clk, !i_rst_n, empty)
    `HWS_ASSERT_NEXT(a_open_after_reset, i_clk, !i_rst_n, !full)
    // Last flag marks exactly the top bin
    `HWS_ASSERT_IMPLY(a_last_is_top, i_clk, i_rst_n, !empty, o_last_bin == (o_bin_index == IdxW'(HalfWin)))
    `HWS_ASSERT_IMPLY(a_index_range, i_clk, i_rst_n, !empty, o_bin_index <= IdxW'(HalfWin) && o_cfg_ready)
endmodule

bind hann_windowed_stft_unit hws_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_bin_index (o_bin_index),
    .o_last_bin  (o_last_bin),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire
